/* rtl/core/riff_wave_header_parser_top_defines.svh */
// Assertion macros shared by the checker of the RIFF/WAVE header parser.
// No dependencies; included by the checker file only.
`ifndef RIFF_WAVE_HEADER_PARSER_TOP_DEFINES_SVH
`define RIFF_WAVE_HEADER_PARSER_TOP_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define RWHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The expression must never be true outside reset.
`define RWHP_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

/* rtl/core/riffwav_pkg.sv */
// Shared types and constants of the RIFF/WAVE header parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package riffwav_pkg;

   localparam int POSITION_BITS_DEF = 32;
   // Header positions can run past the file end by up to one long chunk.
   localparam int HDR_BITS = 34;

   localparam logic [31:0] ID_RIFF = 32'h4646_4952;
   localparam logic [31:0] ID_WAVE = 32'h4556_4157;
   localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
   localparam logic [31:0] ID_CUE  = 32'h2065_7563;
   localparam logic [31:0] ID_LIST = 32'h5453_494C;
   localparam logic [31:0] ID_MARK = 32'h6B72_616D;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_RIFF  = 3'd1;
   localparam logic [2:0] ST_NO_FMT   = 3'd2;
   localparam logic [2:0] ST_NOT_PCM  = 3'd3;
   localparam logic [2:0] ST_NO_DATA  = 3'd4;
   localparam logic [2:0] ST_BAD_LOOP = 3'd5;
   localparam logic [2:0] ST_ZERO_WID = 3'd6;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic byte_go;
      logic tail;
      logic div_init;
      logic div_step;
      logic load;
      logic clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
   } stat_type;

endpackage

`default_nettype wire

/* rtl/core/riff_wave_header_parser_top.sv */
// RIFF/WAVE PCM header parser, use notes:
// The req channel carries one file byte per word, in file order, with
// req_last_byte set on the final byte. The parser takes one byte per cycle
// while it walks the file. After the last byte it works on its own, in
// order: it reads a header cut short by the file end, loads the divider,
// runs the serial divider that forms data length over sample width, and
// registers the result. req_ready is low over that span and while the
// result waits.
// The rsp channel then holds one result word until rsp_ready is seen; a
// stalled receiver simply holds the parser in that state. Once taken, all
// parse state clears and the next byte starts a new file.
// Synchronous reset clears the walk and leaves the parser ready for the
// first byte of a file. Bytes beyond 2^POSITION_BITS - 1 are counted out
// but the last-byte mark still closes the file.
// Depends on riffwav_pkg, riffwav_ctrl and riffwav_dp.
`default_nettype none

module riff_wave_header_parser_top
   import riffwav_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_channels,
   output logic [31:0]      rsp_sample_rate,
   output logic [12:0]      rsp_sample_bytes,
   output logic signed [31:0] rsp_loop_start,
   output logic [31:0]      rsp_sample_count,
   output logic [31:0]      rsp_data_offset
);

   cmd_type  cmd;
   stat_type stat;
   logic [31:0] loop_raw;

   riffwav_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_byte (req_last_byte),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   riffwav_dp #(
      .POSITION_BITS (POSITION_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .byte_value   (req_byte_value),
      .status       (rsp_status),
      .channels     (rsp_channels),
      .sample_rate  (rsp_sample_rate),
      .sample_bytes (rsp_sample_bytes),
      .loop_start   (loop_raw),
      .sample_count (rsp_sample_count),
      .data_offset  (rsp_data_offset)
   );

   assign rsp_loop_start = signed'(loop_raw);

endmodule

`default_nettype wire

/* rtl/core/riffwav_ctrl.sv */
// Controller of the RIFF/WAVE header parser: sequences byte intake,
// end-of-file work, the division and the result handshake. Uses riffwav_pkg.
`default_nettype none

module riffwav_ctrl
   import riffwav_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     req_last_byte,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_RUN, S_TAIL, S_DINIT, S_DIV, S_FIN, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      byte_go;

   assign byte_go   = req_valid && req_ready_ff;
   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.byte_go  = byte_go;
      case (state_ff)
         S_RUN: begin
            if (byte_go && req_last_byte) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            cmd.tail = 1'b1;
            state_in = S_DINIT;
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.load = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               cmd.clear = 1'b1;
               state_in  = S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
      req_ready_in = (state_in == S_RUN);
      rsp_valid_in = (state_in == S_RESP);
   end

   // State and registered handshake outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/riffwav_dp.sv */
// Datapath of the RIFF/WAVE header parser: chunk walk, field capture,
// serial divider and result registers. Uses riffwav_pkg.
`default_nettype none

module riffwav_dp
   import riffwav_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [7:0]  byte_value,
   output logic [2:0]       status,
   output logic [15:0]      channels,
   output logic [31:0]      sample_rate,
   output logic [12:0]      sample_bytes,
   output logic [31:0]      loop_start,
   output logic [31:0]      sample_count,
   output logic [31:0]      data_offset
);

   typedef enum logic [1:0] {PH_SEEK, PH_WAVE, PH_INNER, PH_FAIL} phase_type;

   logic [POSITION_BITS:0] pos_ff, pos_in;
   logic [63:0]            shift_ff, shift_in;
   phase_type              phase_ff, phase_in;
   logic [HDR_BITS-1:0]    hdr_ff, hdr_in;
   logic                   stop_ff, stop_in;
   logic                   fmt_ff, fmt_in, cue_ff, cue_in, list_ff, list_in, data_ff, data_in;
   logic [5:0]             rfmt_ff, rfmt_in, rcue_ff, rcue_in, rlist_ff, rlist_in;
   logic [HDR_BITS-1:0]    dstart_ff, dstart_in;
   logic [15:0]            format_ff, format_in, chan_ff, chan_in, bits_ff, bits_in;
   logic [31:0]            rate_ff, rate_in, loop_ff, loop_in, mlen_ff, mlen_in;
   logic [31:0]            mid_ff, mid_in, dlen_ff, dlen_in;
   logic [13:0]            rem_ff, rem_in;
   logic [31:0]            quo_ff, quo_in;
   logic [4:0]             dcnt_ff, dcnt_in;
   logic [2:0]             st_ff, st_in;
   logic [15:0]            chan_o_ff, chan_o_in;
   logic [31:0]            rate_o_ff, rate_o_in, loop_o_ff, loop_o_in;
   logic [12:0]            wid_o_ff, wid_o_in;
   logic [31:0]            cnt_o_ff, cnt_o_in, dofs_o_ff, dofs_o_in;

   logic                   in_range, byte_en, hit, tail_ok, inner_go;
   logic [HDR_BITS-1:0]    pos_ext, hit_pos, diff, adv;
   logic [63:0]            hdr_word;
   logic [31:0]            id, len, rnd, msum;
   logic [14:0]            trial;
   logic [12:0]            width;
   logic                   mark, msum_use;

   assign in_range = !pos_ff[POSITION_BITS];
   assign byte_en  = cmd.byte_go && in_range;
   assign pos_ext  = HDR_BITS'(pos_ff);
   assign hit_pos  = hdr_ff + ((phase_ff == PH_WAVE) ? HDR_BITS'(11) : HDR_BITS'(7));
   assign hit      = byte_en && (pos_ext == hit_pos);
   assign shift_in = byte_en ? {byte_value, shift_ff[63:8]} : shift_ff;
   assign diff     = pos_ext - hdr_ff;

   // A header cut short by the file end is read from the partial shift word.
   always_comb begin
      tail_ok  = cmd.tail && (phase_ff == PH_INNER) && !stop_ff && (hdr_ff < pos_ext)
                 && (diff >= HDR_BITS'(5)) && (diff <= HDR_BITS'(7));
      hdr_word = {byte_value, shift_ff[63:8]};
      if (cmd.tail) begin
         case (diff[1:0])
            2'd3:    hdr_word = {8'd0, shift_ff[63:8]};
            2'd2:    hdr_word = {16'd0, shift_ff[63:16]};
            2'd1:    hdr_word = {24'd0, shift_ff[63:24]};
            default: hdr_word = shift_ff;
         endcase
      end
   end

   assign id       = hdr_word[31:0];
   assign len      = hdr_word[63:32];
   assign rnd      = (len + 32'd1) & ~32'd1;
   assign adv      = hdr_ff + HDR_BITS'(8) + HDR_BITS'(rnd);
   assign inner_go = (hit && (phase_ff == PH_INNER) && !stop_ff) || tail_ok;

   // Chunk walk and field capture.
   always_comb begin
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      hdr_in    = hdr_ff;
      stop_in   = stop_ff;
      fmt_in    = fmt_ff;
      cue_in    = cue_ff;
      list_in   = list_ff;
      data_in   = data_ff;
      rfmt_in   = rfmt_ff;
      rcue_in   = rcue_ff;
      rlist_in  = rlist_ff;
      dstart_in = dstart_ff;
      format_in = format_ff;
      chan_in   = chan_ff;
      bits_in   = bits_ff;
      rate_in   = rate_ff;
      loop_in   = loop_ff;
      mlen_in   = mlen_ff;
      mid_in    = mid_ff;
      dlen_in   = dlen_ff;

      if (byte_en) begin
         pos_in = pos_ff + 1'b1;
         // Bytes land in the fields of chunks already found.
         if (fmt_ff) begin
            case (rfmt_ff)
               6'd8:    format_in[7:0]   = byte_value;
               6'd9:    format_in[15:8]  = byte_value;
               6'd10:   chan_in[7:0]     = byte_value;
               6'd11:   chan_in[15:8]    = byte_value;
               6'd12:   rate_in[7:0]     = byte_value;
               6'd13:   rate_in[15:8]    = byte_value;
               6'd14:   rate_in[23:16]   = byte_value;
               6'd15:   rate_in[31:24]   = byte_value;
               6'd22:   bits_in[7:0]     = byte_value;
               6'd23:   bits_in[15:8]    = byte_value;
               default: format_in        = format_ff;
            endcase
            if (rfmt_ff != 6'd63) rfmt_in = rfmt_ff + 6'd1;
         end
         if (cue_ff) begin
            case (rcue_ff)
               6'd32:   loop_in[7:0]   = byte_value;
               6'd33:   loop_in[15:8]  = byte_value;
               6'd34:   loop_in[23:16] = byte_value;
               6'd35:   loop_in[31:24] = byte_value;
               default: loop_in        = loop_ff;
            endcase
            if (rcue_ff != 6'd63) rcue_in = rcue_ff + 6'd1;
         end
         if (list_ff) begin
            case (rlist_ff)
               6'd24:   mlen_in[7:0]   = byte_value;
               6'd25:   mlen_in[15:8]  = byte_value;
               6'd26:   mlen_in[23:16] = byte_value;
               6'd27:   mlen_in[31:24] = byte_value;
               6'd28:   mid_in[7:0]    = byte_value;
               6'd29:   mid_in[15:8]   = byte_value;
               6'd30:   mid_in[23:16]  = byte_value;
               6'd31:   mid_in[31:24]  = byte_value;
               default: mid_in         = mid_ff;
            endcase
            if (rlist_ff != 6'd63) rlist_in = rlist_ff + 6'd1;
         end
      end

      // Top-level walk to the RIFF chunk and the WAVE check.
      if (hit && (phase_ff == PH_SEEK)) begin
         if (len[31]) begin
            phase_in = PH_FAIL;
         end else if (id == ID_RIFF) begin
            phase_in = PH_WAVE;
         end else begin
            hdr_in = adv;
         end
      end
      if (hit && (phase_ff == PH_WAVE)) begin
         if (len == ID_WAVE) begin
            phase_in = PH_INNER;
            hdr_in   = hdr_ff + HDR_BITS'(12);
         end else begin
            phase_in = PH_FAIL;
         end
      end

      // Inner chunk headers.
      if (inner_go) begin
         if (len[31]) begin
            stop_in = 1'b1;
         end else begin
            if ((id == ID_FMT) && !fmt_ff) begin
               fmt_in  = 1'b1;
               rfmt_in = 6'd8;
            end
            if ((id == ID_CUE) && !cue_ff) begin
               cue_in  = 1'b1;
               rcue_in = 6'd8;
            end else if ((id == ID_LIST) && cue_ff && !list_ff) begin
               list_in  = 1'b1;
               rlist_in = 6'd8;
            end
            if ((id == ID_DATA) && !data_ff) begin
               data_in   = 1'b1;
               dstart_in = hdr_ff;
               dlen_in   = len;
            end
            hdr_in = adv;
         end
      end
   end

   // Restoring divider, one quotient bit per cycle.
   assign trial = {rem_ff, quo_ff[31]} - {2'b00, width};
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dcnt_in = dcnt_ff;
      if (cmd.div_init) begin
         rem_in  = '0;
         quo_in  = dlen_ff;
         dcnt_in = '0;
      end else if (cmd.div_step) begin
         if (!trial[14]) begin
            rem_in = trial[13:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[12:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         dcnt_in = dcnt_ff + 5'd1;
      end
   end
   assign stat.div_done = cmd.div_step && (dcnt_ff == 5'd31);

   // Result from the captured fields.
   assign width    = bits_ff[15:3];
   assign mark     = list_ff && (rlist_ff >= 6'd32) && (mid_ff == ID_MARK);
   assign msum     = loop_ff + mlen_ff;
   assign msum_use = mark && (msum != 32'd0) && !msum[31];
   always_comb begin
      st_in     = ST_OK;
      chan_o_in = '0;
      rate_o_in = '0;
      wid_o_in  = '0;
      loop_o_in = '0;
      cnt_o_in  = '0;
      dofs_o_in = '0;
      if (phase_ff != PH_INNER) begin
         st_in = ST_NO_RIFF;
      end else if (!fmt_ff) begin
         st_in = ST_NO_FMT;
      end else if (format_ff != 16'd1) begin
         st_in = ST_NOT_PCM;
      end else begin
         chan_o_in = chan_ff;
         rate_o_in = rate_ff;
         wid_o_in  = width;
         loop_o_in = cue_ff ? loop_ff : 32'hFFFF_FFFF;
         if (!data_ff) begin
            st_in = ST_NO_DATA;
         end else if (width == 13'd0) begin
            st_in = ST_ZERO_WID;
         end else if (msum_use && (quo_ff < msum)) begin
            st_in = ST_BAD_LOOP;
         end else begin
            cnt_o_in  = msum_use ? msum : quo_ff;
            dofs_o_in = 32'(dstart_ff + HDR_BITS'(8));
         end
      end
   end

   // Parse state, cleared at reset and after each result.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         pos_ff    <= '0;
         shift_ff  <= '0;
         phase_ff  <= PH_SEEK;
         hdr_ff    <= '0;
         stop_ff   <= 1'b0;
         fmt_ff    <= 1'b0;
         cue_ff    <= 1'b0;
         list_ff   <= 1'b0;
         data_ff   <= 1'b0;
         rfmt_ff   <= '0;
         rcue_ff   <= '0;
         rlist_ff  <= '0;
         dstart_ff <= '0;
         format_ff <= '0;
         chan_ff   <= '0;
         bits_ff   <= '0;
         rate_ff   <= '0;
         loop_ff   <= '0;
         mlen_ff   <= '0;
         mid_ff    <= '0;
         dlen_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         shift_ff  <= shift_in;
         phase_ff  <= phase_in;
         hdr_ff    <= hdr_in;
         stop_ff   <= stop_in;
         fmt_ff    <= fmt_in;
         cue_ff    <= cue_in;
         list_ff   <= list_in;
         data_ff   <= data_in;
         rfmt_ff   <= rfmt_in;
         rcue_ff   <= rcue_in;
         rlist_ff  <= rlist_in;
         dstart_ff <= dstart_in;
         format_ff <= format_in;
         chan_ff   <= chan_in;
         bits_ff   <= bits_in;
         rate_ff   <= rate_in;
         loop_ff   <= loop_in;
         mlen_ff   <= mlen_in;
         mid_ff    <= mid_in;
         dlen_ff   <= dlen_in;
      end
   end

   // Divider and result registers.
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dcnt_ff <= dcnt_in;
      if (cmd.load) begin
         st_ff     <= st_in;
         chan_o_ff <= chan_o_in;
         rate_o_ff <= rate_o_in;
         wid_o_ff  <= wid_o_in;
         loop_o_ff <= loop_o_in;
         cnt_o_ff  <= cnt_o_in;
         dofs_o_ff <= dofs_o_in;
      end
   end

   assign status       = st_ff;
   assign channels     = chan_o_ff;
   assign sample_rate  = rate_o_ff;
   assign sample_bytes = wid_o_ff;
   assign loop_start   = loop_o_ff;
   assign sample_count = cnt_o_ff;
   assign data_offset  = dofs_o_ff;

endmodule

`default_nettype wire

/* rtl/core/riffwav_checker.sv */
// Port-level checker for the RIFF/WAVE header parser, bound to the top.
// Depends on riffwav_pkg and the macros in riff_wave_header_parser_top_defines.svh.
`default_nettype none
`include "riff_wave_header_parser_top_defines.svh"

module riffwav_checker
   import riffwav_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_last_byte,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_status
);

   // A waiting result word stays offered.
   `RWHP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
   // Intake and result never overlap.
   `RWHP_ASSERT_NEVER(a_excl, clock, reset, req_ready && rsp_valid, "intake open with result")
   // The last byte closes intake.
   `RWHP_ASSERT_NEXT(a_last_stop, clock, reset, req_valid && req_ready && req_last_byte, !req_ready, "intake open")
   // One result per file.
   `RWHP_ASSERT_NEXT(a_one_rsp, clock, reset, rsp_valid && rsp_ready, !rsp_valid && (rsp_status <= ST_ZERO_WID), "result repeated")

endmodule

bind riff_wave_header_parser_top riffwav_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_last_byte (req_last_byte),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status)
);

`default_nettype wire

/* tb/riff_wave_header_parser_top_tb.sv */
// Self-checking testbench for the RIFF/WAVE PCM header parser: whole files are streamed in byte
// words, a behavioural model predicts each header result and a monitor checks every rsp word.
// Depends on riffwav_pkg and riff_wave_header_parser_top.
`default_nettype none

module riff_wave_header_parser_top_tb;
   import riffwav_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES = 400;
   localparam int TARGET_BYTES = 1650;

   // Chunk slots and captured field slots of the parser model.
   localparam int CH_RIFF = 0;
   localparam int CH_FMT = 1;
   localparam int CH_CUE = 2;
   localparam int CH_LIST = 3;
   localparam int CH_DATA = 4;
   localparam int FL_WAVE = 5;
   localparam int FD_FORMAT = 0;
   localparam int FD_CHAN = 1;
   localparam int FD_RATE = 2;
   localparam int FD_BITS = 3;
   localparam int FD_LOOP = 4;
   localparam int FD_MLEN = 5;
   localparam int FD_MID = 6;
   localparam int FD_DLEN = 7;

   typedef enum logic [1:0] {WALK_SEEK, WALK_WAVE, WALK_INNER, WALK_FAIL} walk_phase_type;

   typedef struct packed {
      logic [7:0] value;
      logic       is_last;
   } file_byte_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [15:0]        channels;
      logic [31:0]        sample_rate;
      logic [12:0]        sample_bytes;
      logic signed [31:0] loop_start;
      logic [31:0]        sample_count;
      logic [31:0]        data_offset;
   } header_info_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_byte_value = 8'd0;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [15:0] rsp_channels;
   logic [31:0] rsp_sample_rate;
   logic [12:0] rsp_sample_bytes;
   logic signed [31:0] rsp_loop_start;
   logic [31:0] rsp_sample_count;
   logic [31:0] rsp_data_offset;

   file_byte_type pending_bytes[$];
   header_info_type expected_headers[$];
   logic [7:0] chunk_parts[6][$];
   int total_bytes = 0;
   int bytes_taken = 0;
   int error_count = 0;
   int cycle_count = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;

   // Model state of the parser.
   logic [63:0] model_pos;
   walk_phase_type model_phase;
   logic [63:0] model_next_hdr;
   logic [63:0] model_shift;
   logic [5:0] model_found;
   logic [63:0] model_starts[5];
   logic [31:0] model_fields[8];
   logic model_stopped;

   riff_wave_header_parser_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_byte_value(req_byte_value), .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_channels(rsp_channels),
      .rsp_sample_rate(rsp_sample_rate), .rsp_sample_bytes(rsp_sample_bytes),
      .rsp_loop_start(rsp_loop_start), .rsp_sample_count(rsp_sample_count),
      .rsp_data_offset(rsp_data_offset)
   );

   // Clock generation.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void clear_model();
      model_pos = 64'd0;
      model_phase = WALK_SEEK;
      model_next_hdr = 64'd0;
      model_shift = 64'd0;
      model_found = 6'd0;
      model_stopped = 1'b0;
      for (int i = 0; i < 5; i++) model_starts[i] = 64'd0;
      for (int i = 0; i < 8; i++) model_fields[i] = 32'd0;
   endfunction

   function automatic logic [63:0] chunk_after(logic [63:0] start, logic [31:0] len);
      return start + 64'd8 + (({32'd0, len} + 64'd1) & ~64'd1);
   endfunction

   // One inner chunk header: record the first chunks of interest and step over the body.
   function automatic void take_inner_header(logic [63:0] hdr);
      logic [31:0] id;
      logic [31:0] len;
      logic [63:0] h;
      id = hdr[31:0];
      len = hdr[63:32];
      h = model_next_hdr;
      if (len[31]) begin
         model_stopped = 1'b1;
         return;
      end
      if (id == ID_FMT && !model_found[CH_FMT]) begin
         model_found[CH_FMT] = 1'b1;
         model_starts[CH_FMT] = h;
      end
      if (id == ID_CUE && !model_found[CH_CUE]) begin
         model_found[CH_CUE] = 1'b1;
         model_starts[CH_CUE] = h;
      end else if (id == ID_LIST && model_found[CH_CUE] && !model_found[CH_LIST]) begin
         model_found[CH_LIST] = 1'b1;
         model_starts[CH_LIST] = h;
      end
      if (id == ID_DATA && !model_found[CH_DATA]) begin
         model_found[CH_DATA] = 1'b1;
         model_starts[CH_DATA] = h;
         model_fields[FD_DLEN] = len;
      end
      model_next_hdr = chunk_after(h, len);
   endfunction

   function automatic void capture_field(int chunk, int offs, int n, logic [63:0] p,
                                         logic [7:0] b, int slot);
      logic [63:0] s;
      if (!model_found[chunk]) return;
      s = model_starts[chunk] + 64'(offs);
      if (p >= s && p < s + 64'(n))
         model_fields[slot] = model_fields[slot] | (32'(b) << (8 * (p - s)));
   endfunction

   // Advances the parser model by one byte; returns 1 with the header info on the last byte.
   function automatic logic parse_wave_byte(logic [7:0] b, logic is_last,
                                            output header_info_type info);
      logic [63:0] p;
      logic [63:0] h;
      logic [31:0] width;
      logic [31:0] msum;
      logic [31:0] quot;
      info = '0;
      p = model_pos;
      model_pos = model_pos + 64'd1;
      model_shift = {b, model_shift[63:8]};
      if (model_phase == WALK_SEEK && p == model_next_hdr + 64'd7) begin
         if (model_shift[63]) model_phase = WALK_FAIL;
         else if (model_shift[31:0] == ID_RIFF) begin
            model_found[CH_RIFF] = 1'b1;
            model_starts[CH_RIFF] = model_next_hdr;
            model_phase = WALK_WAVE;
         end else model_next_hdr = chunk_after(model_next_hdr, model_shift[63:32]);
      end else if (model_phase == WALK_WAVE && p == model_starts[CH_RIFF] + 64'd11) begin
         if (model_shift[63:32] == ID_WAVE) begin
            model_found[FL_WAVE] = 1'b1;
            model_phase = WALK_INNER;
            model_next_hdr = model_starts[CH_RIFF] + 64'd12;
         end else model_phase = WALK_FAIL;
      end else if (model_phase == WALK_INNER && !model_stopped
                   && p == model_next_hdr + 64'd7) begin
         take_inner_header(model_shift);
      end
      capture_field(CH_FMT, 8, 2, p, b, FD_FORMAT);
      capture_field(CH_FMT, 10, 2, p, b, FD_CHAN);
      capture_field(CH_FMT, 12, 4, p, b, FD_RATE);
      capture_field(CH_FMT, 22, 2, p, b, FD_BITS);
      capture_field(CH_CUE, 32, 4, p, b, FD_LOOP);
      capture_field(CH_LIST, 24, 4, p, b, FD_MLEN);
      capture_field(CH_LIST, 28, 4, p, b, FD_MID);
      if (!is_last) return 1'b0;

      // A header cut short by the end of the file still counts when its length began.
      if (model_phase == WALK_INNER && !model_stopped) begin
         h = model_next_hdr;
         if (h + 64'd4 < model_pos && h + 64'd8 > model_pos)
            take_inner_header(model_shift >> (8 * (h + 64'd8 - model_pos)));
      end

      if (model_phase != WALK_INNER) info.status = ST_NO_RIFF;
      else if (!model_found[CH_FMT]) info.status = ST_NO_FMT;
      else if (model_fields[FD_FORMAT][15:0] != 16'd1) info.status = ST_NOT_PCM;
      else begin
         msum = 32'd0;
         width = 32'(model_fields[FD_BITS][15:0]) / 32'd8;
         info.channels = model_fields[FD_CHAN][15:0];
         info.sample_rate = model_fields[FD_RATE];
         info.sample_bytes = width[12:0];
         info.loop_start = model_found[CH_CUE] ? model_fields[FD_LOOP] : 32'hFFFF_FFFF;
         if (model_found[CH_CUE] && model_found[CH_LIST]
             && model_starts[CH_LIST] + 64'd32 <= model_pos
             && model_fields[FD_MID] == ID_MARK)
            msum = model_fields[FD_LOOP] + model_fields[FD_MLEN];
         if (!model_found[CH_DATA]) info.status = ST_NO_DATA;
         else if (width == 32'd0) info.status = ST_ZERO_WID;
         else begin
            quot = model_fields[FD_DLEN] / width;
            info.status = ST_OK;
            if (msum != 32'd0 && !msum[31]) begin
               if (quot < msum) info.status = ST_BAD_LOOP;
               else info.sample_count = msum;
            end else info.sample_count = quot;
            if (info.status == ST_OK) info.data_offset = model_starts[CH_DATA][31:0] + 32'd8;
         end
      end
      clear_model();
      return 1'b1;
   endfunction

   task automatic put_le(int part, logic [31:0] v, int n);
      for (int i = 0; i < n; i++) chunk_parts[part].push_back(v[8*i +: 8]);
   endtask

   task automatic put_filler(int part, int n);
      for (int i = 0; i < n; i++) chunk_parts[part].push_back(8'($urandom));
   endtask

   // Queues one file; keep_bytes of zero keeps the whole file, else a longer file is cut to that size.
   task automatic queue_file(int keep_bytes, logic shuffle);
      logic [7:0] whole[$];
      int order[5];
      int j;
      int t;
      order = '{1, 2, 3, 4, 5};
      if (shuffle) begin
         for (int i = 4; i > 0; i--) begin
            j = $urandom_range(i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
         end
      end
      whole = chunk_parts[0];
      for (int i = 0; i < 5; i++) whole = {whole, chunk_parts[order[i]]};
      if (keep_bytes > 0 && keep_bytes < whole.size()) whole = whole[0:keep_bytes-1];
      if (whole.size() == 0) whole.push_back(8'($urandom));
      foreach (whole[i]) pending_bytes.push_back('{whole[i], i == whole.size() - 1});
      total_bytes += whole.size();
      for (int i = 0; i < 6; i++) chunk_parts[i].delete();
   endtask

   // Builds the chunks of one WAVE file into the part queues.
   task automatic build_wave(logic lead_junk, logic [31:0] riff_id, logic [31:0] wave_id,
                             logic [31:0] riff_len, logic has_fmt, logic [15:0] fmt_tag,
                             logic [15:0] bits, logic has_cue, logic [31:0] loop_at,
                             logic has_list, logic [31:0] list_tag, logic [31:0] mark_len,
                             logic has_data, logic [31:0] data_len, int data_bytes,
                             logic has_junk, logic [31:0] junk_len);
      int n;
      if (lead_junk) begin
         n = $urandom_range(9);
         put_le(0, $urandom & 32'hFFFF_FF00, 4);
         put_le(0, 32'(n), 4);
         put_filler(0, n + (n & 1));
      end
      put_le(0, riff_id, 4);
      put_le(0, riff_len, 4);
      put_le(0, wave_id, 4);
      if (has_fmt) begin
         n = ($urandom_range(3) == 0) ? 17 : 16;
         put_le(1, ID_FMT, 4);
         put_le(1, 32'(n), 4);
         put_le(1, 32'(fmt_tag), 2);
         put_le(1, $urandom, 2);
         put_le(1, $urandom, 4);
         put_filler(1, 6);
         put_le(1, 32'(bits), 2);
         put_filler(1, n - 16 + (n & 1));
      end
      if (has_cue) begin
         put_le(2, ID_CUE, 4);
         put_le(2, 32'd28, 4);
         put_filler(2, 20);
         put_le(2, loop_at, 4);
      end
      if (has_list) begin
         put_le(3, ID_LIST, 4);
         put_le(3, 32'd24, 4);
         put_filler(3, 16);
         put_le(3, mark_len, 4);
         put_le(3, list_tag, 4);
      end
      if (has_data) begin
         put_le(4, ID_DATA, 4);
         put_le(4, data_len, 4);
         put_filler(4, data_bytes + (data_bytes & 1));
      end
      if (has_junk) begin
         put_le(5, $urandom, 4);
         put_le(5, junk_len, 4);
         n = junk_len[31] ? 0 : 32'(junk_len);
         put_filler(5, n + (n & 1));
      end
   endtask

   function automatic logic [15:0] pick_bits();
      case ($urandom_range(5))
         0: return 16'd8;
         1: return 16'd16;
         2: return 16'd24;
         3: return 16'($urandom_range(7));
         4: return 16'($urandom);
         default: return 16'd32;
      endcase
   endfunction

   task automatic queue_random_file();
      int dn;
      logic [31:0] loop_at;
      logic [31:0] mark_len;
      if ($urandom_range(9) == 0) begin
         // Plain noise with no structure.
         put_filler(0, $urandom_range(1, 30));
         queue_file(0, 1'b0);
         return;
      end
      dn = $urandom_range(24);
      loop_at = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(8));
      mark_len = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(12));
      build_wave($urandom_range(3) == 0,
                 ($urandom_range(19) == 0) ? $urandom : ID_RIFF,
                 ($urandom_range(14) == 0) ? $urandom : ID_WAVE,
                 ($urandom_range(29) == 0) ? 32'h8000_0000 | $urandom : $urandom >> 1,
                 $urandom_range(9) != 0,
                 ($urandom_range(7) == 0) ? 16'($urandom) : 16'd1,
                 pick_bits(),
                 $urandom_range(1), loop_at,
                 $urandom_range(3) != 0,
                 ($urandom_range(4) == 0) ? $urandom : ID_MARK, mark_len,
                 $urandom_range(7) != 0,
                 ($urandom_range(9) == 0) ? $urandom : 32'(dn), dn,
                 $urandom_range(2) == 0,
                 ($urandom_range(15) == 0) ? 32'h8000_0000 | $urandom
                                           : 32'($urandom_range(7)));
      queue_file(($urandom_range(7) == 0) ? $urandom_range(1, 120) : 0, $urandom_range(1));
   endtask

   // Sender: offers the next byte word, with random gaps by phase of the run.
   always @(posedge clock) begin
      file_byte_type nxt;
      header_info_type info;
      logic busy;
      int idle_pct;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         busy = req_valid;
         if (req_valid && req_ready) begin
            if (parse_wave_byte(req_byte_value, req_last_byte, info))
               expected_headers.push_back(info);
            bytes_taken <= bytes_taken + 1;
            busy = 1'b0;
         end
         idle_pct = (bytes_taken < total_bytes / 3) ? 36 :
                    (bytes_taken < 2 * total_bytes / 3) ? 53 : 0;
         if (!busy) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
               nxt = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_byte_value <= nxt.value;
               req_last_byte <= nxt.is_last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off once the run reaches its last third.
   always @(posedge clock) begin
      if (!reset && !hold_done && total_bytes > 0 && bytes_taken >= 2 * total_bytes / 3) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
      error_count++;
   endtask

   // Receiver: checks each result word against the oldest prediction.
   always @(posedge clock) begin
      header_info_type want;
      int idle_pct;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_headers.size() == 0) begin
               report_mismatch("unexpected word status", 32'(rsp_status), 32'd0);
            end else begin
               want = expected_headers.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_channels !== want.channels)
                  report_mismatch("channels", 32'(rsp_channels), 32'(want.channels));
               if (rsp_sample_rate !== want.sample_rate)
                  report_mismatch("sample_rate", rsp_sample_rate, want.sample_rate);
               if (rsp_sample_bytes !== want.sample_bytes)
                  report_mismatch("sample_bytes", 32'(rsp_sample_bytes),
                                  32'(want.sample_bytes));
               if (rsp_loop_start !== want.loop_start)
                  report_mismatch("loop_start", rsp_loop_start, want.loop_start);
               if (rsp_sample_count !== want.sample_count)
                  report_mismatch("sample_count", rsp_sample_count, want.sample_count);
               if (rsp_data_offset !== want.data_offset)
                  report_mismatch("data_offset", rsp_data_offset, want.data_offset);
            end
         end
         idle_pct = (bytes_taken < total_bytes / 3) ? 53 :
                    (bytes_taken < 2 * total_bytes / 3) ? 36 : 0;
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      clear_model();
      // Directed files: a good file, then each error status and the odd corners.
      build_wave(0, ID_RIFF, ID_WAVE, 32'd200, 1, 16'd1, 16'd16, 1, 32'd2, 1, ID_MARK,
                 32'd3, 1, 32'd20, 20, 0, 32'd0);
      queue_file(0, 1'b0);
      put_le(0, 32'h0, 1);
      queue_file(0, 1'b0);
      put_le(0, 32'hFFFF_FFFF, 4);
      put_le(0, 32'hFFFF_FFFF, 4);
      queue_file(0, 1'b0);
      build_wave(1, ID_RIFF, 32'h1234_5678, 32'd40, 1, 16'd1, 16'd8, 0, 0, 0, 0, 0, 1,
                 32'd4, 4, 0, 0);
      queue_file(0, 1'b0);
      build_wave(0, ID_RIFF, ID_WAVE, 32'd40, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'd4, 4, 0, 0);
      queue_file(0, 1'b0);
      build_wave(0, ID_RIFF, ID_WAVE, 32'd40, 1, 16'hFFFE, 16'd16, 0, 0, 0, 0, 0, 1,
                 32'd4, 4, 0, 0);
      queue_file(0, 1'b0);
      build_wave(0, ID_RIFF, ID_WAVE, 32'd40, 1, 16'd1, 16'd7, 0, 0, 0, 0, 0, 1,
                 32'd4, 4, 0, 0);
      queue_file(0, 1'b0);
      build_wave(0, ID_RIFF, ID_WAVE, 32'd40, 1, 16'd1, 16'hFFFF, 1, 32'hFFFF_FFFF, 0, 0, 0,
                 0, 0, 0, 1, 32'd3);
      queue_file(0, 1'b0);
      build_wave(0, ID_RIFF, ID_WAVE, 32'd90, 1, 16'd1, 16'd8, 1, 32'd100, 1, ID_MARK,
                 32'd1000, 1, 32'd10, 10, 0, 0);
      queue_file(0, 1'b0);
      build_wave(0, ID_RIFF, ID_WAVE, 32'd90, 1, 16'd1, 16'd8, 1, 32'd5, 1, ID_MARK,
                 32'hFFFF_FFFB, 1, 32'd11, 11, 1, 32'h8000_0000);
      queue_file(0, 1'b0);
      build_wave(0, ID_RIFF, ID_WAVE, 32'd90, 1, 16'd1, 16'd24, 0, 0, 0, 0, 0, 1,
                 32'h7FFF_FFFF, 2, 0, 0);
      queue_file(0, 1'b0);
      build_wave(0, ID_RIFF, ID_WAVE, 32'd90, 1, 16'd1, 16'd16, 0, 0, 0, 0, 0, 1,
                 32'd8, 8, 0, 0);
      queue_file(42, 1'b0);
      build_wave(0, ID_RIFF, ID_WAVE, 32'h8000_0000, 1, 16'd1, 16'd16, 0, 0, 0, 0, 0, 1,
                 32'd8, 8, 0, 0);
      queue_file(0, 1'b0);

      // Random files until enough bytes are queued.
      while (total_bytes < TARGET_BYTES) begin
         queue_random_file();
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() > 0 || req_valid || expected_headers.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
